/* rtl/range_lock_value_table_defines.svh */
// ----------------------------------------------------------------------------
// Range lock value table assertion macros
// Same-cycle and next-cycle implication checks on clock, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_LOCK_VALUE_TABLE_DEFINES_SVH
`define RANGE_LOCK_VALUE_TABLE_DEFINES_SVH

// same-cycle implication
`define RLVT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("range lock value table assertion failed");

// next-cycle implication
`define RLVT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("range lock value table assertion failed");

`endif

/* rtl/rlvt_pkg.sv */
// ----------------------------------------------------------------------------
// Range lock value table package
// Sizes, request kind codes and the store access bundle.
// ----------------------------------------------------------------------------
package rlvt_pkg;

   localparam int NUM_LOCATIONS = 1024;
   localparam int VALUE_BITS    = 16;
   localparam int ADDR_BITS     = $clog2(NUM_LOCATIONS);
   localparam int CNT_BITS      = ADDR_BITS + 1;
   localparam int KIND_BITS     = 3;
   localparam int START_BITS    = 10;
   localparam int FENCE_BITS    = 11;
   localparam int OPERAND_BITS  = 16;
   localparam int READ_BITS     = 16;
   localparam int CMP_BITS      = (VALUE_BITS > OPERAND_BITS) ? VALUE_BITS : OPERAND_BITS;
   localparam int WIDE_BITS     = (CNT_BITS > FENCE_BITS) ? CNT_BITS : FENCE_BITS;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_READ      = 3'd0,
      KIND_ADD       = 3'd1,
      KIND_SET       = 3'd2,
      KIND_CHECK_EQ  = 3'd3,
      KIND_CHECK_GT  = 3'd4
   } kind_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic [VALUE_BITS-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_BITS-1:0]  rd_addr;
   } mem_req_type;

endpackage

/* rtl/rlvt_ram.sv */
// ----------------------------------------------------------------------------
// Range lock value table store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rlvt_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rlvt_ctrl.sv */
// ----------------------------------------------------------------------------
// Range lock value table sequencer
// Clears the store after reset, then walks each request's range one location
// a cycle: read, modify, write back, and folds the check result.
// ----------------------------------------------------------------------------
`include "range_lock_value_table_defines.svh"

module rlvt_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [rlvt_pkg::KIND_BITS-1:0]        req_kind,
   input  logic [rlvt_pkg::START_BITS-1:0]       req_range_start,
   input  logic [rlvt_pkg::FENCE_BITS-1:0]       req_range_fence,
   input  logic signed [rlvt_pkg::OPERAND_BITS-1:0] req_operand,
   output logic                                  rsp_strobe,
   output logic signed [rlvt_pkg::READ_BITS-1:0] rsp_read_value,
   output logic                                  rsp_check_passed,
   output rlvt_pkg::mem_req_type                 mem_req,
   input  logic [rlvt_pkg::VALUE_BITS-1:0]       mem_rd_data
);

   localparam int AB = rlvt_pkg::ADDR_BITS;
   localparam int CB = rlvt_pkg::CNT_BITS;
   localparam int VB = rlvt_pkg::VALUE_BITS;
   localparam int WB = rlvt_pkg::WIDE_BITS;
   localparam int MB = rlvt_pkg::CMP_BITS;
   localparam int RB = rlvt_pkg::READ_BITS;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type                        state_ff;
   logic [CB-1:0]                    addr_ff;
   logic [CB-1:0]                    fence_ff;
   rlvt_pkg::kind_type               kind_ff;
   logic signed [rlvt_pkg::OPERAND_BITS-1:0] operand_ff;
   logic                             pend_ff;
   logic [AB-1:0]                    pend_addr_ff;
   logic                             passed_ff;
   logic signed [RB-1:0]             read_ff;
   logic                             rsp_strobe_ff;
   logic signed [RB-1:0]             rsp_read_value_ff;
   logic                             rsp_check_passed_ff;

   logic [WB-1:0]        start_w;
   logic [WB-1:0]        fence_w;
   logic [WB-1:0]        num_w;
   logic [WB-1:0]        start_c;
   logic [WB-1:0]        fence_c;
   logic [WB-1:0]        read_fence;
   logic [CB-1:0]        fence_in;
   logic                 accept;
   logic                 rd_go;
   logic                 clear_last;
   logic [VB-1:0]        op_val;
   logic signed [MB-1:0] op_cmp;
   logic signed [MB-1:0] cur_sext;
   logic [VB-1:0]        sum;
   logic                 check_fail;
   logic                 writes_back;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   assign start_w    = WB'(req_range_start);
   assign fence_w    = WB'(req_range_fence);
   assign num_w      = WB'(rlvt_pkg::NUM_LOCATIONS);
   assign start_c    = (start_w > num_w) ? num_w : start_w;
   assign fence_c    = (fence_w > num_w) ? num_w : fence_w;
   assign read_fence = (start_w < num_w) ? WB'(start_w + WB'(1)) : num_w;

   always_comb begin
      case (rlvt_pkg::kind_type'(req_kind)) inside
         rlvt_pkg::KIND_READ: fence_in = CB'(read_fence);
         rlvt_pkg::KIND_ADD, rlvt_pkg::KIND_SET,
         rlvt_pkg::KIND_CHECK_EQ, rlvt_pkg::KIND_CHECK_GT: fence_in = CB'(fence_c);
         default: fence_in = CB'(start_c);
      endcase
   end

   assign rd_go      = (addr_ff < fence_ff);
   assign clear_last = (addr_ff == CB'(rlvt_pkg::NUM_LOCATIONS - 1));

   assign op_val   = VB'(operand_ff);
   assign op_cmp   = MB'(operand_ff);
   assign cur_sext = MB'(signed'(mem_rd_data));
   assign sum      = VB'(mem_rd_data + op_val);

   always_comb begin
      check_fail  = 1'b0;
      writes_back = 1'b0;
      case (kind_ff) inside
         rlvt_pkg::KIND_ADD, rlvt_pkg::KIND_SET: writes_back = 1'b1;
         rlvt_pkg::KIND_CHECK_EQ: check_fail = (cur_sext != op_cmp);
         rlvt_pkg::KIND_CHECK_GT: check_fail = (cur_sext <= op_cmp);
         default: ;
      endcase
   end

   always_comb begin
      mem_req = '0;
      if (state_ff == ST_CLEAR) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = addr_ff[AB-1:0];
         mem_req.wr_data = '0;
      end else if (state_ff == ST_WALK) begin
         mem_req.rd_en   = rd_go;
         mem_req.rd_addr = addr_ff[AB-1:0];
         mem_req.wr_en   = pend_ff && writes_back;
         mem_req.wr_addr = pend_addr_ff;
         mem_req.wr_data = (kind_ff == rlvt_pkg::KIND_ADD) ? sum : op_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               addr_ff <= CB'(addr_ff + CB'(1));
               if (clear_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff   <= ST_WALK;
                  addr_ff    <= CB'(start_c);
                  fence_ff   <= fence_in;
                  kind_ff    <= rlvt_pkg::kind_type'(req_kind);
                  operand_ff <= req_operand;
                  passed_ff  <= 1'b1;
                  read_ff    <= '0;
                  pend_ff    <= 1'b0;
               end
            end
            ST_WALK: begin
               pend_ff      <= rd_go;
               pend_addr_ff <= addr_ff[AB-1:0];
               if (rd_go) begin
                  addr_ff <= CB'(addr_ff + CB'(1));
               end
               if (pend_ff) begin
                  if (check_fail) begin
                     passed_ff <= 1'b0;
                  end
                  if (kind_ff == rlvt_pkg::KIND_READ) begin
                     read_ff <= RB'(cur_sext);
                  end
               end
               if (!rd_go && !pend_ff) begin
                  state_ff            <= ST_IDLE;
                  rsp_strobe_ff       <= 1'b1;
                  rsp_read_value_ff   <= read_ff;
                  rsp_check_passed_ff <= passed_ff;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_read_value   = rsp_read_value_ff;
   assign rsp_check_passed = rsp_check_passed_ff;

   `RLVT_ASSERT_NEXT(a_strobe_single, rsp_strobe_ff, !rsp_strobe_ff)
   `RLVT_ASSERT_NEXT(a_accept_busy, accept, busy && !rsp_strobe_ff)
   `RLVT_ASSERT_NOW(a_no_rw_same_entry, mem_req.wr_en && mem_req.rd_en, mem_req.wr_addr != mem_req.rd_addr)
   `RLVT_ASSERT_NOW(a_walk_in_bounds, mem_req.rd_en, addr_ff < CB'(rlvt_pkg::NUM_LOCATIONS))

endmodule

/* rtl/range_lock_value_table.sv */
// A request answers with its strobe once every location of its range has been
//   read and handled; a read covers one location and an empty range none.
// Throughput: one request at a time; one location per cycle; busy stays high
//   from acceptance to the strobe.
// Reset: the store's 1024 entries are swept to zero, one entry a cycle, with busy high.
// Results carry a one-cycle strobe and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// Range lock value table
// Signed lock value per location with range add, set, read and checks.
// ----------------------------------------------------------------------------
module range_lock_value_table (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [rlvt_pkg::KIND_BITS-1:0]           req_kind,
   input  logic [rlvt_pkg::START_BITS-1:0]          req_range_start,
   input  logic [rlvt_pkg::FENCE_BITS-1:0]          req_range_fence,
   input  logic signed [rlvt_pkg::OPERAND_BITS-1:0] req_operand,
   output logic                                     rsp_strobe,
   output logic signed [rlvt_pkg::READ_BITS-1:0]    rsp_read_value,
   output logic                                     rsp_check_passed
);

   rlvt_pkg::mem_req_type                 mem_req;
   logic [rlvt_pkg::VALUE_BITS-1:0]       mem_rd_data;

   rlvt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_range_start  (req_range_start),
      .req_range_fence  (req_range_fence),
      .req_operand      (req_operand),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_value   (rsp_read_value),
      .rsp_check_passed (rsp_check_passed),
      .mem_req          (mem_req),
      .mem_rd_data      (mem_rd_data)
   );

   rlvt_ram #(
      .DEPTH (rlvt_pkg::NUM_LOCATIONS),
      .WIDTH (rlvt_pkg::VALUE_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range lock value table testbench
// Sends range add, set, read and check requests through the start/busy
// handshake. A mirror of the store predicts each result, and every strobed
// result is compared in order against the predictions. Directed requests
// cover the cleared store, value extremes with wrap, fence clamping, empty
// ranges and the unused kinds. Random set/add/check sequences over small
// windows follow, then random noise and a final back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NL = rlvt_pkg::NUM_LOCATIONS;
   localparam int KB = rlvt_pkg::KIND_BITS;
   localparam int SB = rlvt_pkg::START_BITS;
   localparam int FB = rlvt_pkg::FENCE_BITS;
   localparam int OB = rlvt_pkg::OPERAND_BITS;
   localparam int VB = rlvt_pkg::VALUE_BITS;
   localparam int RB = rlvt_pkg::READ_BITS;

   localparam logic [SB-1:0] LAST_LOCATION = SB'(NL - 1);
   localparam logic [FB-1:0] FENCE_MAX     = '1;
   localparam logic [FB-1:0] FENCE_FULL    = FB'(NL);
   localparam logic signed [OB-1:0] OPERAND_MAX = {1'b0, {(OB-1){1'b1}}};
   localparam logic signed [OB-1:0] OPERAND_MIN = {1'b1, {(OB-1){1'b0}}};

   typedef struct packed {
      logic signed [RB-1:0] read_value;
      logic                 check_passed;
   } lock_answer_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [KB-1:0]        req_kind;
   logic [SB-1:0]        req_range_start;
   logic [FB-1:0]        req_range_fence;
   logic signed [OB-1:0] req_operand;
   logic                 rsp_strobe;
   logic signed [RB-1:0] rsp_read_value;
   logic                 rsp_check_passed;

   logic [VB-1:0]   lock_mirror [NL];
   lock_answer_type expected_answers [$];
   lock_answer_type oldest_answer;
   int              mismatch_count = 0;
   int              requests_sent  = 0;
   bit              sender_gaps    = 1'b1;

   range_lock_value_table u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_range_start  (req_range_start),
      .req_range_fence  (req_range_fence),
      .req_operand      (req_operand),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_value   (rsp_read_value),
      .rsp_check_passed (rsp_check_passed)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic longint widen_value(logic [VB-1:0] stored);
      return longint'($signed(stored));
   endfunction

   function automatic lock_answer_type apply_lock_request(
      logic [KB-1:0] kind, logic [SB-1:0] first,
      logic [FB-1:0] fence, logic signed [OB-1:0] operand);
      lock_answer_type answer;
      longint          limit;
      longint          opnd;
      longint          read_wide;
      logic [VB-1:0]   op_bits;
      longint          idx;
      answer.read_value   = '0;
      answer.check_passed = 1'b1;
      limit   = (int'(fence) > NL) ? longint'(NL) : longint'(fence);
      opnd    = longint'(operand);
      op_bits = opnd[VB-1:0];
      case (kind)
         rlvt_pkg::KIND_READ: begin
            if (int'(first) < NL) begin
               read_wide         = widen_value(lock_mirror[first]);
               answer.read_value = read_wide[RB-1:0];
            end
         end
         rlvt_pkg::KIND_ADD: begin
            for (idx = longint'(first); idx < limit; idx++)
               lock_mirror[idx] = lock_mirror[idx] + op_bits;
         end
         rlvt_pkg::KIND_SET: begin
            for (idx = longint'(first); idx < limit; idx++)
               lock_mirror[idx] = op_bits;
         end
         rlvt_pkg::KIND_CHECK_EQ: begin
            for (idx = longint'(first); idx < limit; idx++)
               if (widen_value(lock_mirror[idx]) != opnd) begin
                  answer.check_passed = 1'b0;
                  break;
               end
         end
         rlvt_pkg::KIND_CHECK_GT: begin
            for (idx = longint'(first); idx < limit; idx++)
               if (widen_value(lock_mirror[idx]) <= opnd) begin
                  answer.check_passed = 1'b0;
                  break;
               end
         end
         default: ;
      endcase
      return answer;
   endfunction

   function automatic logic signed [OB-1:0] random_operand();
      case ($urandom_range(0, 3))
         0:       return OB'($urandom_range(0, 8) - 4);
         1:       return $urandom_range(0, 1) ? OPERAND_MAX : OPERAND_MIN;
         default: return OB'($urandom);
      endcase
   endfunction

   task automatic issue_lock_request(input logic [KB-1:0] kind,
                                     input logic [SB-1:0] first,
                                     input logic [FB-1:0] fence,
                                     input logic signed [OB-1:0] operand);
      int gap;
      gap = (sender_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind        = kind;
      req_range_start = first;
      req_range_fence = fence;
      req_operand     = operand;
      start           = 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      expected_answers.push_back(apply_lock_request(kind, first, fence, operand));
      requests_sent++;
   endtask

   task automatic pick_window(output logic [SB-1:0] first,
                              output logic [FB-1:0] fence);
      int len;
      first = SB'($urandom_range(0, NL - 1));
      len   = ($urandom_range(0, 49) == 0) ? $urandom_range(0, NL)
                                           : $urandom_range(0, 48);
      fence = FB'(int'(first) + len);
   endtask

   always @(posedge clock) begin
      if (rsp_strobe === 1'b1) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected request result read_value %0d check_passed %0b",
                     $time, rsp_read_value, rsp_check_passed);
            mismatch_count++;
         end else begin
            oldest_answer = expected_answers.pop_front();
            if (rsp_read_value !== oldest_answer.read_value) begin
               $display("%0t: read_value expected %0d, actual %0d",
                        $time, oldest_answer.read_value, rsp_read_value);
               mismatch_count++;
            end
            if (rsp_check_passed !== oldest_answer.check_passed) begin
               $display("%0t: check_passed expected %0b, actual %0b",
                        $time, oldest_answer.check_passed, rsp_check_passed);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_cleared_store();
      issue_lock_request(rlvt_pkg::KIND_READ, 0, 0, 0);
      issue_lock_request(rlvt_pkg::KIND_READ, LAST_LOCATION, FENCE_MAX, OPERAND_MAX);
      issue_lock_request(rlvt_pkg::KIND_CHECK_EQ, 0, FENCE_FULL, 0);
      issue_lock_request(rlvt_pkg::KIND_CHECK_GT, 0, FENCE_MAX, OPERAND_MIN);
   endtask

   task automatic test_value_extremes();
      issue_lock_request(rlvt_pkg::KIND_SET, LAST_LOCATION - 3, FENCE_MAX, OPERAND_MAX);
      issue_lock_request(rlvt_pkg::KIND_READ, LAST_LOCATION, 0, 0);
      issue_lock_request(rlvt_pkg::KIND_ADD, LAST_LOCATION - 1, FENCE_FULL, 1);
      issue_lock_request(rlvt_pkg::KIND_READ, LAST_LOCATION, 0, 0);
      issue_lock_request(rlvt_pkg::KIND_READ, LAST_LOCATION - 2, 0, 0);
      issue_lock_request(rlvt_pkg::KIND_CHECK_GT, LAST_LOCATION - 3, FENCE_FULL,
                         OPERAND_MIN);
      issue_lock_request(rlvt_pkg::KIND_CHECK_EQ, LAST_LOCATION - 3, FENCE_FULL - 2,
                         OPERAND_MAX);
      issue_lock_request(rlvt_pkg::KIND_CHECK_GT, 0, 1, OPERAND_MAX);
      issue_lock_request(rlvt_pkg::KIND_SET, 0, 1, OPERAND_MIN);
      issue_lock_request(rlvt_pkg::KIND_ADD, 0, 1, -1);
      issue_lock_request(rlvt_pkg::KIND_READ, 0, 0, 0);
   endtask

   task automatic test_empty_ranges();
      issue_lock_request(rlvt_pkg::KIND_ADD, 0, 0, 5);
      issue_lock_request(rlvt_pkg::KIND_ADD, 10, 10, OPERAND_MAX);
      issue_lock_request(rlvt_pkg::KIND_SET, 500, 3, 7);
      issue_lock_request(rlvt_pkg::KIND_CHECK_EQ, 600, 600, 99);
      issue_lock_request(rlvt_pkg::KIND_CHECK_GT, LAST_LOCATION, 5, OPERAND_MAX);
   endtask

   task automatic test_unused_kinds();
      int code;
      for (code = int'(rlvt_pkg::KIND_CHECK_GT) + 1; code < 2**KB; code++)
         issue_lock_request(KB'(code), SB'($urandom), FB'($urandom), random_operand());
   endtask

   task automatic test_window_sequences(input int request_goal, input bit with_gaps);
      logic [SB-1:0]        first;
      logic [FB-1:0]        fence;
      logic signed [OB-1:0] level;
      logic signed [OB-1:0] delta;
      int                   span;
      sender_gaps = with_gaps;
      while (requests_sent < request_goal) begin
         pick_window(first, fence);
         span  = ((int'(fence) > NL) ? NL : int'(fence)) - int'(first);
         level = random_operand();
         issue_lock_request(rlvt_pkg::KIND_SET, first, fence, level);
         repeat ($urandom_range(0, 3)) begin
            delta = random_operand();
            issue_lock_request(rlvt_pkg::KIND_ADD, first, fence, delta);
            level = level + delta;
         end
         issue_lock_request(rlvt_pkg::KIND_CHECK_EQ, first, fence, level);
         issue_lock_request(rlvt_pkg::KIND_CHECK_GT, first, fence, level - 1);
         if ($urandom_range(0, 1))
            issue_lock_request(rlvt_pkg::KIND_CHECK_EQ, first, fence,
                               level ^ OB'(1 << $urandom_range(0, OB - 1)));
         if ($urandom_range(0, 1))
            issue_lock_request(rlvt_pkg::KIND_CHECK_GT, first, fence, level);
         if (span > 0)
            issue_lock_request(rlvt_pkg::KIND_READ,
                               SB'(int'(first) + $urandom_range(0, span - 1)),
                               FB'($urandom), OB'($urandom));
         else
            issue_lock_request(rlvt_pkg::KIND_READ, SB'($urandom), FB'($urandom),
                               OB'($urandom));
      end
   endtask

   task automatic test_random_noise(input int request_count);
      logic [SB-1:0] first;
      logic [FB-1:0] fence;
      sender_gaps = 1'b1;
      repeat (request_count) begin
         pick_window(first, fence);
         if ($urandom_range(0, 7) == 0)
            fence = FB'($urandom);
         issue_lock_request(KB'($urandom), first, fence, random_operand());
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_kind        = '0;
      req_range_start = '0;
      req_range_fence = '0;
      req_operand     = '0;
      foreach (lock_mirror[idx])
         lock_mirror[idx] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_cleared_store();
      test_value_extremes();
      test_empty_ranges();
      test_unused_kinds();
      test_window_sequences(1150, 1'b1);
      test_random_noise(200);
      test_window_sequences(requests_sent + 150, 1'b0);

      @(negedge clock);
      start = 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

/* range_lock_value_table.f */
+incdir+rtl
rtl/rlvt_pkg.sv
rtl/rlvt_ram.sv
rtl/rlvt_ctrl.sv
rtl/range_lock_value_table.sv
tb/sv/tb_top.sv
